>>> hw/rtl/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared constants, codes and the result type of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Default sizing of the managed zone.
  localparam int PAGE_COUNT_DEF      = 4096;
  localparam int MAX_BLOCK_ORDER_DEF = 10;

  // Fixed field widths of the transaction ports.
  localparam int CMD_W  = 1;
  localparam int ORD_W  = 4;
  localparam int IDX_W  = 12;
  localparam int STAT_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  // One result transaction.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  index;
    logic [ORD_W-1:0]  order;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/bpa_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy allocator page memory
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module bpa_mem #(
  parameter int Depth = 4096,
  parameter int Width = 29
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Runs allocate and free requests as read-modify-write steps on the page
// memory and keeps the per-order list heads and counts in registers.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
  parameter int PageCount = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MaxOrder  = bpa_pkg::MAX_BLOCK_ORDER_DEF,
  localparam int IW = $clog2(PageCount),
  localparam int WW = 2 * IW + 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [bpa_pkg::CMD_W-1:0]    command_i,
  input  wire logic [bpa_pkg::ORD_W-1:0]    order_i,
  input  wire logic [bpa_pkg::IDX_W-1:0]    block_index_i,
  output logic                              res_valid_o,
  output bpa_pkg::res_t                     res_o,
  input  wire logic                         res_take_i,
  output logic                              mem_we_o,
  output logic      [IW-1:0]                mem_waddr_o,
  output logic      [WW-1:0]                mem_wdata_o,
  output logic                              mem_re_o,
  output logic      [IW-1:0]                mem_raddr_o,
  input  wire logic [WW-1:0]                mem_rdata_i
);

  localparam int NumLists = MaxOrder + 1;
  localparam int LW       = (NumLists > 1) ? $clog2(NumLists) : 1;
  localparam int CW       = LW + 1;
  localparam int CNTW     = IW + 1;
  localparam int SW       = ((IW > MaxOrder) ? IW : MaxOrder) + 3;
  localparam int Managed  = (PageCount >> MaxOrder) << MaxOrder;
  localparam int HeadInit = (Managed > 0) ? Managed - (1 << MaxOrder) : 0;

  localparam logic [SW-1:0] BlkS = {{(SW-1){1'b0}}, 1'b1} << MaxOrder;
  localparam logic [SW-1:0] ManS = SW'(Managed);

  // Sequencer states.
  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SRCH  = 4'd2;
  localparam logic [3:0] ST_UL0   = 4'd3;
  localparam logic [3:0] ST_OPS   = 4'd4;
  localparam logic [3:0] ST_OPW   = 4'd5;
  localparam logic [3:0] ST_SPLIT = 4'd6;
  localparam logic [3:0] ST_FCHK  = 4'd7;
  localparam logic [3:0] ST_FBUD  = 4'd8;
  localparam logic [3:0] ST_FBCHK = 4'd9;
  localparam logic [3:0] ST_FMRG  = 4'd10;
  localparam logic [3:0] ST_FPUSH = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // Memory step kinds.
  localparam logic [1:0] OP_SETNEXT = 2'd0;
  localparam logic [1:0] OP_SETPREV = 2'd1;
  localparam logic [1:0] OP_CLRFREE = 2'd2;
  localparam logic [1:0] OP_FULL    = 2'd3;

  function automatic logic [IW-1:0] clip_i(input logic [IW-1:0] x);
    return (SW'(x) < SW'(PageCount)) ? x : '0;
  endfunction

  function automatic logic [IW-1:0] clip_s(input logic [SW-1:0] x);
    return (x < SW'(PageCount)) ? x[IW-1:0] : '0;
  endfunction

  logic [3:0]          state_q, state_d, ret_q, ret_d;
  logic [IW-1:0]       clr_q;
  logic [CW-1:0]       c_q, c_d, ord_q, ord_d;
  logic [SW-1:0]       base_q, base_d, bud_q, bud_d;
  logic [IW-1:0]       u_q, u_d;
  logic [LW-1:0]       uo_q, uo_d;
  bpa_pkg::res_t       res_q, res_d;
  logic [IW-1:0]       heads_q  [NumLists];
  logic [CNTW-1:0]     counts_q [NumLists];

  // Pending memory steps, executed from slot zero.
  logic [1:0]          op_kind_q [3];
  logic [IW-1:0]       op_addr_q [3];
  logic [IW-1:0]       op_val_q  [3];
  logic [3:0]          op_ord_q;
  logic [1:0]          op_cnt_q;

  logic                op_load, op_shift;
  logic [1:0]          ld_kind [3];
  logic [IW-1:0]       ld_addr [3];
  logic [IW-1:0]       ld_val  [3];
  logic [3:0]          ld_ord;
  logic [1:0]          ld_cnt;

  logic                hd_we, ct_we;
  logic [LW-1:0]       lst_idx;
  logic [IW-1:0]       hd_val;
  logic [CNTW-1:0]     ct_val;

  logic                do_push;
  logic [IW-1:0]       pnode;
  logic [LW-1:0]       pord;

  logic [IW-1:0]       w_next, w_prev, ul_p, ul_n;
  logic                w_free, ul_tail, ul_head;
  logic [3:0]          w_ord;
  logic [SW-1:0]       clr_s, clr_next, clr_prev;
  logic                clr_base;
  logic [SW-1:0]       in_base, in_end, in_mask, bud;
  logic [CW-1:0]       cn;
  logic [WW-1:0]       mod_word;

  // Fields of the word read from the page memory, and the unlink decisions.
  always_comb begin
    w_next  = mem_rdata_i[WW-1 -: IW];
    w_prev  = mem_rdata_i[WW-1-IW -: IW];
    w_free  = mem_rdata_i[4];
    w_ord   = mem_rdata_i[3:0];
    ul_p    = clip_i(w_prev);
    ul_n    = clip_i(w_next);
    ul_tail = (ul_n == u_q);
    ul_head = (counts_q[uo_q] != '0) && (heads_q[uo_q] == u_q);
  end

  // Initial word of the page under the clearing pass.
  always_comb begin
    clr_s    = SW'(clr_q);
    clr_base = ((clr_s & (BlkS - SW'(1))) == '0) && (clr_s < ManS);
    clr_next = (clr_s == '0) ? '0 : clr_s - BlkS;
    clr_prev = ((clr_s + BlkS) >= ManS) ? clr_s : clr_s + BlkS;
  end

  // Base and end of a block being freed, and the buddy of the current block.
  always_comb begin
    in_mask = (SW'(1) << order_i) - SW'(1);
    in_base = SW'(block_index_i) & ~in_mask;
    in_end  = in_base + (SW'(1) << order_i);
    bud     = base_q ^ (SW'(1) << ord_q);
    cn      = c_q - CW'(1);
  end

  // Word written back by a read-modify-write step.
  always_comb begin
    mod_word = mem_rdata_i;
    case (op_kind_q[0])
      OP_SETNEXT: mod_word[WW-1 -: IW] = op_val_q[0];
      OP_SETPREV: mod_word[WW-1-IW -: IW] = op_val_q[0];
      default:    mod_word[4] = 1'b0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    c_d         = c_q;
    ord_d       = ord_q;
    base_d      = base_q;
    bud_d       = bud_q;
    u_d         = u_q;
    uo_d        = uo_q;
    res_d       = res_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = op_addr_q[0];
    mem_wdata_o = mod_word;
    mem_re_o    = 1'b0;
    mem_raddr_o = op_addr_q[0];
    op_load     = 1'b0;
    op_shift    = 1'b0;
    ld_cnt      = '0;
    ld_ord      = '0;
    for (int i = 0; i < 3; i++) begin
      ld_kind[i] = OP_CLRFREE;
      ld_addr[i] = u_q;
      ld_val[i]  = '0;
    end
    hd_we       = 1'b0;
    ct_we       = 1'b0;
    lst_idx     = uo_q;
    hd_val      = '0;
    ct_val      = '0;
    do_push     = 1'b0;
    pnode       = '0;
    pord        = '0;

    case (state_q)
      ST_CLR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = clr_base ? {clr_next[IW-1:0], clr_prev[IW-1:0], 1'b1, 4'(MaxOrder)}
                               : '0;
        if (clr_q == IW'(PageCount - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (32'(order_i) > 32'(MaxOrder)) begin
            res_d   = '{status: bpa_pkg::STATUS_RANGE, index: '0, order: '0};
            state_d = ST_DONE;
          end else if (command_i == bpa_pkg::CMD_ALLOC) begin
            c_d     = CW'(order_i);
            ord_d   = CW'(order_i);
            state_d = ST_SRCH;
          end else if (in_end > ManS) begin
            res_d   = '{status: bpa_pkg::STATUS_RANGE, index: '0, order: '0};
            state_d = ST_DONE;
          end else begin
            ord_d       = CW'(order_i);
            base_d      = in_base;
            mem_re_o    = 1'b1;
            mem_raddr_o = in_base[IW-1:0];
            state_d     = ST_FCHK;
          end
        end
      end

      // Find the lowest non-empty list at or above the requested order.
      ST_SRCH: begin
        if (32'(c_q) > 32'(MaxOrder)) begin
          res_d   = '{status: bpa_pkg::STATUS_EMPTY, index: '0, order: '0};
          state_d = ST_DONE;
        end else if (counts_q[c_q[LW-1:0]] != '0) begin
          u_d         = heads_q[c_q[LW-1:0]];
          uo_d        = c_q[LW-1:0];
          base_d      = SW'(heads_q[c_q[LW-1:0]]);
          mem_re_o    = 1'b1;
          mem_raddr_o = heads_q[c_q[LW-1:0]];
          ret_d       = ST_SPLIT;
          state_d     = ST_UL0;
        end else begin
          c_d = c_q + CW'(1);
        end
      end

      // Unlink the block whose word has just been read.
      ST_UL0: begin
        op_load = 1'b1;
        ct_we   = 1'b1;
        ct_val  = (counts_q[uo_q] != '0) ? counts_q[uo_q] - CNTW'(1) : '0;
        if (ul_head) begin
          if (!ul_tail) begin
            hd_we      = 1'b1;
            hd_val     = ul_n;
            ld_kind[0] = OP_SETPREV;
            ld_addr[0] = ul_n;
            ld_val[0]  = ul_n;
            ld_cnt     = 2'd2;
          end else begin
            ld_cnt = 2'd1;
          end
        end else begin
          ld_kind[0] = OP_SETNEXT;
          ld_addr[0] = ul_p;
          ld_val[0]  = ul_tail ? ul_p : ul_n;
          if (!ul_tail) begin
            ld_kind[1] = OP_SETPREV;
            ld_addr[1] = ul_n;
            ld_val[1]  = ul_p;
            ld_cnt     = 2'd3;
          end else begin
            ld_cnt = 2'd2;
          end
        end
        state_d = ST_OPS;
      end

      // Run pending memory steps; a read is followed by its write-back, a full word is written at once.
      ST_OPS: begin
        if (op_cnt_q == '0) begin
          state_d = ret_q;
        end else if (op_kind_q[0] == OP_FULL) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {op_val_q[0], op_addr_q[0], 1'b1, op_ord_q};
          op_shift    = 1'b1;
        end else begin
          mem_re_o = 1'b1;
          state_d  = ST_OPW;
        end
      end

      ST_OPW: begin
        mem_we_o = 1'b1;
        op_shift = 1'b1;
        state_d  = ST_OPS;
      end

      // Split down, pushing each upper half.
      ST_SPLIT: begin
        if (c_q > ord_q) begin
          c_d     = cn;
          do_push = 1'b1;
          pnode   = clip_s(base_q + (SW'(1) << cn));
          pord    = cn[LW-1:0];
          ret_d   = ST_SPLIT;
          state_d = ST_OPS;
        end else begin
          res_d   = '{status: bpa_pkg::STATUS_OK, index: bpa_pkg::IDX_W'(base_q),
                      order: bpa_pkg::ORD_W'(ord_q)};
          state_d = ST_DONE;
        end
      end

      ST_FCHK: begin
        if (w_free) begin
          res_d   = '{status: bpa_pkg::STATUS_EMPTY, index: '0, order: '0};
          state_d = ST_DONE;
        end else begin
          state_d = ST_FBUD;
        end
      end

      ST_FBUD: begin
        if ((32'(ord_q) < 32'(MaxOrder)) && (bud < ManS)) begin
          bud_d       = bud;
          mem_re_o    = 1'b1;
          mem_raddr_o = bud[IW-1:0];
          state_d     = ST_FBCHK;
        end else begin
          state_d = ST_FPUSH;
        end
      end

      ST_FBCHK: begin
        if (!w_free || (w_ord != 4'(ord_q))) begin
          state_d = ST_FPUSH;
        end else begin
          u_d     = bud_q[IW-1:0];
          uo_d    = ord_q[LW-1:0];
          ret_d   = ST_FMRG;
          state_d = ST_UL0;
        end
      end

      ST_FMRG: begin
        if (bud_q < base_q) begin
          base_d = bud_q;
        end
        ord_d   = ord_q + CW'(1);
        state_d = ST_FBUD;
      end

      ST_FPUSH: begin
        do_push = 1'b1;
        pnode   = clip_s(base_q);
        pord    = ord_q[LW-1:0];
        res_d   = '{status: bpa_pkg::STATUS_OK, index: bpa_pkg::IDX_W'(base_q),
                    order: bpa_pkg::ORD_W'(ord_q)};
        ret_d   = ST_DONE;
        state_d = ST_OPS;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Push a block onto the head of its list.
    if (do_push) begin
      op_load = 1'b1;
      ld_ord  = 4'(pord);
      lst_idx = pord;
      hd_we   = 1'b1;
      hd_val  = pnode;
      ct_we   = 1'b1;
      ct_val  = counts_q[pord] + CNTW'(1);
      if (counts_q[pord] != '0) begin
        ld_kind[0] = OP_SETPREV;
        ld_addr[0] = heads_q[pord];
        ld_val[0]  = pnode;
        ld_kind[1] = OP_FULL;
        ld_addr[1] = pnode;
        ld_val[1]  = heads_q[pord];
        ld_cnt     = 2'd2;
      end else begin
        ld_kind[0] = OP_FULL;
        ld_addr[0] = pnode;
        ld_val[0]  = pnode;
        ld_cnt     = 2'd1;
      end
    end
  end

  assign res_o = res_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      ret_q    <= ST_IDLE;
      clr_q    <= '0;
      op_cnt_q <= '0;
      for (int i = 0; i < NumLists; i++) begin
        heads_q[i]  <= (i == MaxOrder) ? IW'(HeadInit) : '0;
        counts_q[i] <= (i == MaxOrder) ? CNTW'(Managed >> MaxOrder) : '0;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + IW'(1);
      end
      if (op_load) begin
        op_cnt_q <= ld_cnt;
      end else if (op_shift) begin
        op_cnt_q <= op_cnt_q - 2'd1;
      end
      if (hd_we) begin
        heads_q[lst_idx] <= hd_val;
      end
      if (ct_we) begin
        counts_q[lst_idx] <= ct_val;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    ord_q  <= ord_d;
    base_q <= base_d;
    bud_q  <= bud_d;
    u_q    <= u_d;
    uo_q   <= uo_d;
    res_q  <= res_d;
    if (op_load) begin
      op_ord_q <= ld_ord;
      for (int i = 0; i < 3; i++) begin
        op_kind_q[i] <= ld_kind[i];
        op_addr_q[i] <= ld_addr[i];
        op_val_q[i]  <= ld_val[i];
      end
    end else if (op_shift) begin
      for (int i = 0; i < 2; i++) begin
        op_kind_q[i] <= op_kind_q[i+1];
        op_addr_q[i] <= op_addr_q[i+1];
        op_val_q[i]  <= op_val_q[i+1];
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/buddy_page_allocator.sv
`default_nettype none
// One request is in work at a time; the next is taken once its result enters the output register.
// Reset: a clearing pass writes every word of the page memory first.
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks from per-order free lists.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int PageCount = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MaxOrder  = bpa_pkg::MAX_BLOCK_ORDER_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [bpa_pkg::CMD_W-1:0]    command_i,
  input  wire logic [bpa_pkg::ORD_W-1:0]    order_i,
  input  wire logic [bpa_pkg::IDX_W-1:0]    block_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [bpa_pkg::STAT_W-1:0]   status_o,
  output logic      [bpa_pkg::IDX_W-1:0]    result_index_o,
  output logic      [bpa_pkg::ORD_W-1:0]    result_order_o
);

  localparam int IW = $clog2(PageCount);
  localparam int WW = 2 * IW + 5;

  logic                res_valid, res_take, out_valid_q;
  bpa_pkg::res_t       res, out_q;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [WW-1:0]       mem_wdata, mem_rdata;

  bpa_ctrl #(
    .PageCount(PageCount),
    .MaxOrder (MaxOrder)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .order_i      (order_i),
    .block_index_i(block_index_i),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  bpa_mem #(
    .Depth(PageCount),
    .Width(WW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register: loads when empty or when its transaction leaves.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_index_o = out_q.index;
  assign result_order_o = out_q.order;

endmodule
`default_nettype wire

>>> bench/tb_buddy_page_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free transactions with random bursts, gaps and output
// stalls. A built-in free-list model predicts every result, and a scoreboard
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;

  localparam int PAGES     = 4096;
  localparam int TOP_ORDER = 10;
  localparam int MANAGED   = (PAGES >> TOP_ORDER) << TOP_ORDER;
  localparam int RAND_REQS = 1250;
  localparam int WATCH_MAX = 20000;
  localparam int HOLD_LEN  = 400;

  // Scoreboard with its own copy of the free lists.
  class page_scoreboard;
    int              next_pg[PAGES];
    int              prev_pg[PAGES];
    bit              is_free[PAGES];
    int              blk_ord[PAGES];
    int              head[TOP_ORDER+1];
    int              count[TOP_ORDER+1];
    bpa_pkg::res_t   pending_results[$];
    int              errors;
    int              alloc_ok, free_ok, rejects, checked;

    function new();
      for (int p = 0; p < PAGES; p++) begin
        next_pg[p] = 0;
        prev_pg[p] = 0;
        is_free[p] = 0;
        blk_ord[p] = 0;
      end
      for (int o = 0; o <= TOP_ORDER; o++) begin
        head[o]  = 0;
        count[o] = 0;
      end
      for (int b = 0; b < MANAGED; b += (1 << TOP_ORDER)) push_block(b, TOP_ORDER);
    endfunction

    function void push_block(int node, int o);
      if (count[o] != 0) begin
        next_pg[node]    = head[o];
        prev_pg[head[o]] = node;
      end else begin
        next_pg[node] = node;
      end
      prev_pg[node] = node;
      head[o] = node;
      count[o]++;
      is_free[node] = 1;
      blk_ord[node] = o;
    endfunction

    function void unlink_block(int node, int o);
      int p, n;
      bit tail;
      p = prev_pg[node];
      n = next_pg[node];
      tail = (n == node);
      if (count[o] != 0 && head[o] == node) begin
        if (!tail) begin
          head[o] = n;
          prev_pg[n] = n;
        end
      end else begin
        next_pg[p] = tail ? p : n;
        if (!tail) prev_pg[n] = p;
      end
      if (count[o] != 0) count[o]--;
      is_free[node] = 0;
    endfunction

    // Applies one accepted transaction and queues the result it must give.
    function void note_request(logic [bpa_pkg::CMD_W-1:0] cmd,
                               logic [bpa_pkg::ORD_W-1:0] ord,
                               logic [bpa_pkg::IDX_W-1:0] idx,
                               output bpa_pkg::res_t r);
      int o, c, base, buddy;
      r = '0;
      o = ord;
      if (o > TOP_ORDER) begin
        r.status = bpa_pkg::STATUS_RANGE;
      end else if (cmd == bpa_pkg::CMD_ALLOC) begin
        c = o;
        while (c <= TOP_ORDER && count[c] == 0) c++;
        if (c > TOP_ORDER) begin
          r.status = bpa_pkg::STATUS_EMPTY;
        end else begin
          base = head[c];
          unlink_block(base, c);
          while (c > o) begin
            c--;
            push_block(base + (1 << c), c);
          end
          r.status = bpa_pkg::STATUS_OK;
          r.index  = base[bpa_pkg::IDX_W-1:0];
          r.order  = ord;
        end
      end else begin
        base = idx & ~((1 << o) - 1);
        if (base + (1 << o) > MANAGED) begin
          r.status = bpa_pkg::STATUS_RANGE;
        end else if (is_free[base]) begin
          r.status = bpa_pkg::STATUS_EMPTY;
        end else begin
          while (o < TOP_ORDER) begin
            buddy = base ^ (1 << o);
            if (buddy >= MANAGED || !is_free[buddy] || blk_ord[buddy] != o) break;
            unlink_block(buddy, o);
            if (buddy < base) base = buddy;
            o++;
          end
          push_block(base, o);
          r.status = bpa_pkg::STATUS_OK;
          r.index  = base[bpa_pkg::IDX_W-1:0];
          r.order  = o[bpa_pkg::ORD_W-1:0];
        end
      end
      if (r.status != bpa_pkg::STATUS_OK) rejects++;
      else if (cmd == bpa_pkg::CMD_ALLOC) alloc_ok++;
      else free_ok++;
      pending_results.push_back(r);
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(bpa_pkg::res_t act);
      bpa_pkg::res_t e;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d index=%0d order=%0d",
                 $time, act.status, act.index, act.order);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (act.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
        errors++;
      end
      if (act.index !== e.index) begin
        $display("%0t: index expected %0d actual %0d", $time, e.index, act.index);
        errors++;
      end
      if (act.order !== e.order) begin
        $display("%0t: order expected %0d actual %0d", $time, e.order, act.order);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    int idx;
    int ord;
  } owned_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [bpa_pkg::CMD_W-1:0]  command_i = bpa_pkg::CMD_ALLOC;
  logic [bpa_pkg::ORD_W-1:0]  order_i = '0;
  logic [bpa_pkg::IDX_W-1:0]  block_index_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [bpa_pkg::STAT_W-1:0] status_o;
  logic [bpa_pkg::IDX_W-1:0]  result_index_o;
  logic [bpa_pkg::ORD_W-1:0]  result_order_o;

  page_scoreboard sb = new();
  owned_t         owned_blocks[$];
  bit             hold_off = 0;
  int             idle_cycles = 0;

  buddy_page_allocator u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .order_i,
    .block_index_i, .out_valid_o, .out_stall_i, .status_o, .result_index_o,
    .result_order_o
  );

  always #5 clk_i = ~clk_i;

  // Offers one transaction and waits until it is taken.
  task automatic issue(logic [bpa_pkg::CMD_W-1:0] cmd, int ord, int idx);
    bpa_pkg::res_t r;
    owned_t b;
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    command_i     = cmd;
    order_i       = ord[bpa_pkg::ORD_W-1:0];
    block_index_i = idx[bpa_pkg::IDX_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, ord[bpa_pkg::ORD_W-1:0], idx[bpa_pkg::IDX_W-1:0], r);
    if (cmd == bpa_pkg::CMD_ALLOC && r.status == bpa_pkg::STATUS_OK) begin
      b.idx = r.index;
      b.ord = r.order;
      owned_blocks.push_back(b);
    end
  endtask

  task automatic pause(int n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Frees one held block, now and then with junk in the low index bits.
  // With nothing held, a random free is sent instead.
  task automatic free_owned(bit keep);
    int k;
    owned_t b;
    if (owned_blocks.size() == 0) begin
      issue(bpa_pkg::CMD_FREE, $urandom_range(0, TOP_ORDER), $urandom_range(0, 4095));
      return;
    end
    k = $urandom_range(0, owned_blocks.size() - 1);
    b = owned_blocks[k];
    if (!keep) owned_blocks.delete(k);
    if ($urandom_range(0, 3) == 0)
      issue(bpa_pkg::CMD_FREE, b.ord, b.idx | $urandom_range(0, (1 << b.ord) - 1));
    else issue(bpa_pkg::CMD_FREE, b.ord, b.idx);
  endtask

  // Receiver stall pattern, in a style picked at random from four.
  always @(negedge clk_i) begin
    int mode, tick;
    if (tick % 64 == 0) mode = $urandom_range(0, 3);
    tick++;
    if (hold_off) out_stall_i <= 1'b1;
    else case (mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= $urandom_range(0, 1);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (tick % 8) < 3;
    endcase
  end

  // Result checking.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result({status_o, result_index_o, result_order_o});
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_MAX) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Long receiver hold-off so the block fills and stalls its input.
  initial begin
    repeat (5000) @(negedge clk_i);
    hold_off = 1;
    repeat (HOLD_LEN) @(negedge clk_i);
    hold_off = 0;
  end

  initial begin
    int sel, o, burst;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: range errors, splits and merges, unaligned and double free.
    issue(bpa_pkg::CMD_ALLOC, 15, 0);
    issue(bpa_pkg::CMD_ALLOC, 11, 4095);
    issue(bpa_pkg::CMD_FREE, 12, 'hFFF);
    issue(bpa_pkg::CMD_ALLOC, 0, 0);
    issue(bpa_pkg::CMD_ALLOC, 0, 0);
    issue(bpa_pkg::CMD_ALLOC, 3, 0);
    issue(bpa_pkg::CMD_FREE, 3, owned_blocks[2].idx | 5);
    issue(bpa_pkg::CMD_FREE, 0, owned_blocks[1].idx);
    issue(bpa_pkg::CMD_FREE, 0, owned_blocks[1].idx);
    issue(bpa_pkg::CMD_FREE, 0, owned_blocks[0].idx);
    owned_blocks.delete();
    // Exhaust the zone, then see empty lists and give everything back.
    repeat (4) issue(bpa_pkg::CMD_ALLOC, TOP_ORDER, 0);
    issue(bpa_pkg::CMD_ALLOC, TOP_ORDER, 0);
    issue(bpa_pkg::CMD_ALLOC, 0, 0);
    while (owned_blocks.size() > 0) free_owned(0);
    issue(bpa_pkg::CMD_FREE, TOP_ORDER, 'hC00);

    // Random bursts, mostly well-formed allocate and free pairs.
    for (int n = 0; n < RAND_REQS; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++, n++) begin
        sel = $urandom_range(0, 99);
        if (owned_blocks.size() > 150) sel = 60;
        if (sel < 45 || (sel < 85 && owned_blocks.size() == 0)) begin
          o = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TOP_ORDER) : $urandom_range(0, 3);
          issue(bpa_pkg::CMD_ALLOC, o, $urandom_range(0, 4095));
        end else if (sel < 50) begin
          issue(bpa_pkg::CMD_ALLOC, $urandom_range(TOP_ORDER + 1, 15), $urandom_range(0, 4095));
        end else if (sel < 85) begin
          free_owned(0);
        end else if (sel < 88) begin
          free_owned(1);
        end else begin
          issue(bpa_pkg::CMD_FREE, $urandom_range(0, 15), $urandom_range(0, 4095));
        end
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
    pause(1);

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Checked %0d results: %0d allocations, %0d frees, %0d rejected requests.",
             sb.checked, sb.alloc_ok, sb.free_ok, sb.rejects);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
